// ===== rtl/core/mandelbrot_pixel_colorizer_macros.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_COLORIZER_MACROS_SVH
`define MANDELBROT_PIXEL_COLORIZER_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define MPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define MPC_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPC_ASSERT(label, clk, rst, prop, msg)
`define MPC_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer - package
// Widths, types, fixed-point helpers, band thresholds and palette.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

  localparam int COORD_BITS     = 32;
  localparam int FRAC_BITS      = 28;
  localparam int INDEX_BITS     = 10;
  localparam int ITER_BITS      = 16;
  localparam int STEP_BITS      = 31;
  localparam int PROD_BITS      = 2 * COORD_BITS;
  localparam int STEP_PROD_BITS = INDEX_BITS + STEP_BITS;
  localparam int BAND_MUL_BITS  = ITER_BITS + 7;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COLOR_BITS     = 8;
  localparam int NUM_PCT        = 11;
  localparam int NUM_BANDS      = 13;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [STEP_BITS-1:0]         step_t;
  typedef logic [STEP_PROD_BITS-1:0]    step_prod_t;
  typedef logic [INDEX_BITS-1:0]        index_t;
  typedef logic [ITER_BITS-1:0]         iter_t;
  typedef logic [BAND_MUL_BITS-1:0]     band_prod_t;
  typedef logic [3:0]                   band_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam prod_t  PROD_CMAX = prod_t'(COORD_MAX);
  localparam prod_t  PROD_CMIN = prod_t'(COORD_MIN);
  // escape radius squared, 4.0 in fixed point
  localparam coord_t FOUR = (FRAC_BITS + 2 < COORD_BITS - 1) ?
                            coord_t'(64'd1 << (FRAC_BITS + 2)) : COORD_MAX;

  // register reset values
  localparam coord_t RST_ORIGIN_REAL = coord_t'(-536870912);
  localparam coord_t RST_ORIGIN_IMAG = coord_t'(268435456);
  localparam step_t  RST_STEP_REAL   = step_t'(787173);
  localparam step_t  RST_STEP_IMAG   = step_t'(524782);
  localparam iter_t  RST_MAX_ITER    = iter_t'(255);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ORIGIN_REAL = 3'd0,
    CFG_ORIGIN_IMAG = 3'd1,
    CFG_STEP_REAL   = 3'd2,
    CFG_STEP_IMAG   = 3'd3,
    CFG_MAX_ITER    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_UPD,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic capture;   // latch column/row
    logic load_c;    // compute c, z = c, clear counter
    logic mul;       // register the three products
    logic update;    // z = z^2 + c, count++
    logic load_out;  // write result register
  } dp_cmd_t;

  typedef struct packed {
    logic limit_hit; // counter reached max_iterations
    logic escape;    // |z|^2 > 4 from registered products
    logic out_free;  // result register empty or being taken
  } dp_status_t;

  localparam logic [6:0] BAND_PCT [NUM_PCT] = '{
    7'd90, 7'd70, 7'd50, 7'd30, 7'd20, 7'd10, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1
  };

  // {red, green, blue}
  localparam logic [3*COLOR_BITS-1:0] PALETTE [NUM_BANDS] = '{
    24'h000000, 24'hFF0000, 24'hFFA07A, 24'hFFA500, 24'hFFFF00,
    24'h90EE90, 24'h008000, 24'h00FFFF, 24'hFF6A00, 24'hE64C4C,
    24'hFA0000, 24'h4661FA, 24'h0000FF
  };

  // clamp to the signed coordinate range
  function automatic coord_t coord_sat(input prod_t v);
    coord_t r;
    if (v > PROD_CMAX) r = COORD_MAX;
    else if (v < PROD_CMIN) r = COORD_MIN;
    else r = coord_t'(v);
    return r;
  endfunction

  // product scaled down by 2^FRAC_BITS (2^(FRAC_BITS-1) when dbl),
  // truncated toward zero, then saturated
  function automatic coord_t prod_scale(input prod_t p, input logic dbl);
    prod_t q;
    logic  frac_nz;
    if (dbl) begin
      q       = p >>> (FRAC_BITS - 1);
      frac_nz = |p[FRAC_BITS-2:0];
    end else begin
      q       = p >>> FRAC_BITS;
      frac_nz = |p[FRAC_BITS-1:0];
    end
    if (p[PROD_BITS-1] && frac_nz) q = q + prod_t'(1);
    return coord_sat(q);
  endfunction

  // palette band: count*100 > max*pct, first match wins
  function automatic band_t band_of(input iter_t count, input iter_t max_it);
    band_t      b;
    band_prod_t lhs;
    band_prod_t rhs;
    lhs = band_prod_t'(count) * band_prod_t'(100);
    b   = band_t'(12);
    for (int i = NUM_PCT - 1; i >= 0; i--) begin
      rhs = band_prod_t'(max_it) * band_prod_t'(BAND_PCT[i]);
      if (lhs > rhs) b = band_t'(i + 1);
    end
    if (count >= max_it) b = '0;
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer - controller
// Sequences setup, multiply/update iterations and result write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_ctrl import mpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_MUL;
      ST_MUL:    state_next = status.limit_hit ? ST_FINISH : ST_UPD;
      ST_UPD:    state_next = status.escape ? ST_FINISH : ST_MUL;
      ST_FINISH: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_SETUP:  cmd.load_c   = 1'b1;
      ST_MUL:    cmd.mul      = !status.limit_hit;
      ST_UPD:    cmd.update   = !status.escape;
      ST_FINISH: cmd.load_out = status.out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/mpc_datapath.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer - datapath
// Coordinate mapping, iteration registers, escape test, palette output.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_datapath import mpc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire dp_cmd_t cmd,
  output dp_status_t   status,
  input  wire index_t  column,
  input  wire index_t  row,
  input  wire coord_t  origin_real,
  input  wire coord_t  origin_imag,
  input  wire step_t   step_real,
  input  wire step_t   step_imag,
  input  wire iter_t   max_iterations,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output iter_t        escape_count,
  output color_t       red,
  output color_t       green,
  output color_t       blue
);

  index_t col_q;
  index_t row_q;
  coord_t cr;
  coord_t ci;
  coord_t zr;
  coord_t zi;
  prod_t  prod_rr;
  prod_t  prod_ii;
  prod_t  prod_ri;
  iter_t  iter;

  step_prod_t sr_prod;
  step_prod_t si_prod;
  coord_t     sr_clamp;
  coord_t     si_clamp;
  coord_t     cr_next;
  coord_t     ci_next;
  coord_t     r2;
  coord_t     i2;
  coord_t     x2;
  coord_t     diff;
  coord_t     zr_next;
  coord_t     zi_next;
  logic       escape;
  band_t      band;
  logic [3*COLOR_BITS-1:0] rgb;

  // c = origin + (column*step_real, -row*step_imag)
  always_comb begin
    sr_prod  = step_prod_t'(col_q) * step_prod_t'(step_real);
    si_prod  = step_prod_t'(row_q) * step_prod_t'(step_imag);
    sr_clamp = (sr_prod > step_prod_t'(COORD_MAX)) ? COORD_MAX : coord_t'(sr_prod);
    si_clamp = (si_prod > step_prod_t'(COORD_MAX)) ? COORD_MAX : coord_t'(si_prod);
    cr_next  = coord_sat(prod_t'(origin_real) + prod_t'(sr_clamp));
    ci_next  = coord_sat(prod_t'(origin_imag) - prod_t'(si_clamp));
  end

  // escape test and z update from the registered products
  always_comb begin
    r2      = prod_scale(prod_rr, 1'b0);
    i2      = prod_scale(prod_ii, 1'b0);
    x2      = prod_scale(prod_ri, 1'b1);
    escape  = (prod_t'(r2) + prod_t'(i2)) > prod_t'(FOUR);
    diff    = coord_sat(prod_t'(r2) - prod_t'(i2));
    zr_next = coord_sat(prod_t'(diff) + prod_t'(cr));
    zi_next = coord_sat(prod_t'(x2) + prod_t'(ci));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= column;
      row_q <= row;
    end
    if (cmd.load_c) begin
      cr   <= cr_next;
      ci   <= ci_next;
      zr   <= cr_next;
      zi   <= ci_next;
      iter <= '0;
    end
    if (cmd.mul) begin
      prod_rr <= zr * zr;
      prod_ii <= zi * zi;
      prod_ri <= zr * zi;
    end
    if (cmd.update) begin
      zr   <= zr_next;
      zi   <= zi_next;
      iter <= iter + iter_t'(1);
    end
  end

  assign band = band_of(iter, max_iterations);
  assign rgb  = PALETTE[band];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      escape_count <= iter;
      red          <= rgb[3*COLOR_BITS-1:2*COLOR_BITS];
      green        <= rgb[2*COLOR_BITS-1:COLOR_BITS];
      blue         <= rgb[COLOR_BITS-1:0];
    end
  end

  assign status = '{
    limit_hit: (iter == max_iterations),
    escape:    escape,
    out_free:  (!m_tvalid || m_tready)
  };

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_pixel_colorizer.sv =====
// Flow: an accepted pixel passes setup, then multiply/update iterations until
//   it escapes or its count reaches max_iterations, then the result write.
// One pixel is in process at a time; each iteration passes a multiply state
//   through the three 32x32 multipliers, then a state for the escape test and update.
// Reset: synchronous, clears the controller and result valid; configuration
//   registers return to the default view (-2.0, 1.0) and 255 iterations.
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer - top level
// Escape-time iteration per pixel with a 13-band color palette.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_pixel_colorizer_macros.svh"

module mandelbrot_pixel_colorizer import mpc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration write port
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  // pixel in
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [23:0]               s_tdata,  // column[9:0], row[19:10], zero pad
  // result out
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [39:0]                    m_tdata   // escape_count[15:0], red, green, blue
);

  // configuration registers
  coord_t origin_real;
  coord_t origin_imag;
  step_t  step_real;
  step_t  step_imag;
  iter_t  max_iterations;

  dp_cmd_t    cmd;
  dp_status_t status;

  iter_t  escape_count;
  color_t red;
  color_t green;
  color_t blue;

  // Writes must land only while idle (the block does not enforce this), so no
  // shadowing is needed; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real    <= RST_ORIGIN_REAL;
      origin_imag    <= RST_ORIGIN_IMAG;
      step_real      <= RST_STEP_REAL;
      step_imag      <= RST_STEP_IMAG;
      max_iterations <= RST_MAX_ITER;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_REAL: origin_real    <= coord_t'(cfg_data);
        CFG_ORIGIN_IMAG: origin_imag    <= coord_t'(cfg_data);
        CFG_STEP_REAL:   step_real      <= cfg_data[STEP_BITS-1:0];
        CFG_STEP_IMAG:   step_imag      <= cfg_data[STEP_BITS-1:0];
        CFG_MAX_ITER:    max_iterations <= cfg_data[ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller: one pixel at a time; the result register decouples output
  // stalls so the next pixel is taken while a result waits
  mpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mpc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .column         (s_tdata[INDEX_BITS-1:0]),
    .row            (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
    .origin_real    (origin_real),
    .origin_imag    (origin_imag),
    .step_real      (step_real),
    .step_imag      (step_imag),
    .max_iterations (max_iterations),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .escape_count   (escape_count),
    .red            (red),
    .green          (green),
    .blue           (blue)
  );

  assign m_tdata = {blue, green, red, escape_count};

  // sequential core: a new pixel is never taken on the cycle after one
  `MPC_ASSERT(a_one_in_flight, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second pixel taken while busy")
  // a delivered count never exceeds the iteration limit
  `MPC_ASSERT(a_count_limit, clk, rst, m_tvalid |-> (escape_count <= max_iterations), "escape count above limit")
  // black exactly for points that reached the limit
  `MPC_ASSERT(a_black_inside, clk, rst, m_tvalid |-> ((escape_count == max_iterations) == ({red, green, blue} == '0)), "palette band mismatch")
  // reset leaves an empty result register and an idle controller
  `MPC_ASSERT_NORST(a_reset_idle, clk, rst |=> (!m_tvalid && s_tready), "not idle after reset")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot pixel colorizer - testbench
// Streams pixel items into the colorizer under several views and iteration
// limits, predicts the escape count and palette color of every accepted item
// and compares each returned item field by field. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpc_pkg::*;

  localparam int     CLK_PERIOD   = 10;
  localparam int     RESET_CYCLES = 10;
  localparam int     ITEM_TARGET  = 1650;
  localparam int     MAX_GAP      = 13;
  localparam int     SETTLE       = 4;     // quiet cycles before a register write
  localparam int     DRAIN_CYCLES = 600;   // above the longest 255-iteration latency
  localparam longint LIMIT_CYCLES = 5_000_000;
  localparam int     MAX_SHOWN    = 100;
  localparam int     PAD_BITS     = 24 - 2 * INDEX_BITS;
  localparam int     LAST_INDEX   = (1 << CFG_INDEX_BITS) - 1;

  // one expected output item, tagged with the pixel it belongs to
  typedef struct {
    iter_t  count;
    color_t red;
    color_t green;
    color_t blue;
    index_t column;
    index_t row;
  } pixel_color_t;

  // --------------------------------------------------------------------------
  // Escape-time predictor and result store
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    longint       origin_re;
    longint       origin_im;
    longint       step_re;
    longint       step_im;
    longint       iter_limit;
    pixel_color_t colors_due[$];
    int           errors;
    int           checked;
    int           shown;
    int           bands_hit[NUM_BANDS];

    function new();
      origin_re  = longint'(RST_ORIGIN_REAL);
      origin_im  = longint'(RST_ORIGIN_IMAG);
      step_re    = longint'(RST_STEP_REAL);
      step_im    = longint'(RST_STEP_IMAG);
      iter_limit = longint'(RST_MAX_ITER);
    endfunction

    // mirror of a register write; unknown indexes change nothing
    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                            logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ORIGIN_REAL: origin_re  = longint'($signed(data));
        CFG_ORIGIN_IMAG: origin_im  = longint'($signed(data));
        CFG_STEP_REAL:   step_re    = longint'(data[STEP_BITS-1:0]);
        CFG_STEP_IMAG:   step_im    = longint'(data[STEP_BITS-1:0]);
        CFG_MAX_ITER:    iter_limit = longint'(data[ITER_BITS-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
      if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
      return v;
    endfunction

    // exact product, scaled down with truncation toward zero, saturated
    function longint scaled(longint a, longint b, int sh);
      return clamp((a * b) / (longint'(1) << sh));
    endfunction

    function pixel_color_t colorize(index_t col, index_t row);
      pixel_color_t              res;
      longint                    cr, ci, zr, zi, r2, i2, count;
      int                        band;
      logic [3*COLOR_BITS-1:0]   rgb;
      cr    = clamp(origin_re + clamp(longint'(col) * step_re));
      ci    = clamp(origin_im - clamp(longint'(row) * step_im));
      zr    = cr;
      zi    = ci;
      count = iter_limit;
      for (longint i = 0; i < iter_limit; i++) begin
        r2 = scaled(zr, zr, FRAC_BITS);
        i2 = scaled(zi, zi, FRAC_BITS);
        if (r2 + i2 > longint'(FOUR)) begin
          count = i;
          break;
        end
        zi = clamp(scaled(zr, zi, FRAC_BITS - 1) + ci);
        zr = clamp(clamp(r2 - i2) + cr);
      end
      // never escaped (or zero limit) is black, otherwise first band that holds
      if (count >= iter_limit) begin
        band = 0;
      end else begin
        band = NUM_BANDS - 1;
        for (int k = 0; k < NUM_PCT; k++) begin
          if (count * 100 > iter_limit * longint'(BAND_PCT[k])) begin
            band = k + 1;
            break;
          end
        end
      end
      rgb        = PALETTE[band];
      res.count  = iter_t'(count);
      res.red    = rgb[23:16];
      res.green  = rgb[15:8];
      res.blue   = rgb[7:0];
      res.column = col;
      res.row    = row;
      bands_hit[band]++;
      return res;
    endfunction

    function void note_pixel(index_t col, index_t row);
      colors_due.push_back(colorize(col, row));
    endfunction

    function int pending();
      return colors_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (shown < MAX_SHOWN) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end else if (shown == MAX_SHOWN) begin
        $display("[%0t] further mismatches counted but not shown", $time);
      end
      shown++;
    endtask

    task check_result(logic [39:0] data);
      pixel_color_t want;
      iter_t        got_count;
      color_t       got_red, got_green, got_blue;
      got_count = data[15:0];
      got_red   = data[23:16];
      got_green = data[31:24];
      got_blue  = data[39:32];
      if (colors_due.size() == 0) begin
        report($sformatf("output item %h with nothing outstanding", data));
        return;
      end
      want = colors_due.pop_front();
      checked++;
      if (got_count !== want.count)
        report($sformatf("pixel (%0d,%0d) escape_count %0d, predicted %0d",
                         want.column, want.row, got_count, want.count));
      if (got_red !== want.red)
        report($sformatf("pixel (%0d,%0d) red %0d, predicted %0d",
                         want.column, want.row, got_red, want.red));
      if (got_green !== want.green)
        report($sformatf("pixel (%0d,%0d) green %0d, predicted %0d",
                         want.column, want.row, got_green, want.green));
      if (got_blue !== want.blue)
        report($sformatf("pixel (%0d,%0d) blue %0d, predicted %0d",
                         want.column, want.row, got_blue, want.blue));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [23:0]               s_tdata   = '0;   // column[9:0], row[19:10], zero pad
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [39:0]               m_tdata;          // escape_count[15:0], red, green, blue

  always #(CLK_PERIOD / 2) clk = ~clk;

  mandelbrot_pixel_colorizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  pixel_scoreboard pix_sb = new();

  int items_sent = 0;
  int views_run  = 0;
  bit feed_gaps  = 1'b1;   // input side idles between items when set
  bit sink_stall = 1'b1;   // output side holds off when set

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // one register write, then the enable is dropped and the scoreboard mirror updated
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    pix_sb.write_reg(idx, data);
  endtask

  task automatic load_view(input logic [CFG_DATA_BITS-1:0] ore, oim, sre, sim, lim);
    write_reg(CFG_ORIGIN_REAL, ore);
    write_reg(CFG_ORIGIN_IMAG, oim);
    write_reg(CFG_STEP_REAL, sre);
    write_reg(CFG_STEP_IMAG, sim);
    write_reg(CFG_MAX_ITER, lim);
  endtask

  // offers one pixel item; returns at the edge where it was taken
  task automatic send_pixel(input index_t col, input index_t row);
    int gap;
    gap = feed_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_BITS{1'b0}}, row, col};
    do @(posedge clk); while (!s_tready);
    pix_sb.note_pixel(col, row);
    items_sent++;
  endtask

  // stop feeding and let every outstanding pixel come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pix_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly a span of a few units, sometimes zoomed in, sometimes anything
  // (bit 31 set there checks the 31-bit mask)
  function automatic logic [CFG_DATA_BITS-1:0] random_step();
    case ($urandom_range(0, 9))
      7, 8:    return $urandom_range(0, 1 << 12);
      9:       return $urandom;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic index_t pick_index();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return index_t'($urandom);
    endcase
  endfunction

  task automatic random_view();
    logic [CFG_DATA_BITS-1:0] ore, oim, lim;
    int                       pick;
    // origins mostly around the set (-2.5..1.0, -1.5..1.5), else anywhere
    ore = ($urandom_range(0, 9) < 7) ?
          CFG_DATA_BITS'(-671088640 + int'($urandom_range(0, 939524096))) : $urandom;
    oim = ($urandom_range(0, 9) < 7) ?
          CFG_DATA_BITS'(-402653184 + int'($urandom_range(0, 805306368))) : $urandom;
    // short limits keep the run fast; junk in the upper half checks the mask
    pick = $urandom_range(0, 19);
    if (pick < 12)       lim = $urandom_range(1, 64);
    else if (pick < 17)  lim = $urandom_range(65, 255);
    else if (pick == 17) lim = $urandom_range(0, 3);
    else                 lim = {16'($urandom), 16'($urandom_range(0, 255))};
    load_view(ore, oim, random_step(), random_step(), lim);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_INDEX_BITS'($urandom_range(CFG_MAX_ITER + 1, LAST_INDEX)), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random hold-off with stall-free stretches
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_stall = !sink_stall;
      stall = sink_stall ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      pix_sb.check_result(m_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int bands_seen;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default view: corners, interior points, a point just off the real axis at -2 (|z|^2 just above 4)
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    send_pixel(683, 511);
    send_pixel(300, 511);
    send_pixel(0, 511);
    wait_idle();

    // most negative real edge, most positive imaginary edge, widest steps:
    // step products saturate; one iteration allowed
    load_view(COORD_MIN, COORD_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1, 1);
    send_pixel(512, 0);
    wait_idle();

    // full 16-bit limit: instant escape, then c near zero running to the limit
    write_reg(CFG_MAX_ITER, 32'h0000_FFFF);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    wait_idle();

    // zero limit via a write whose low half is clear: no iteration, black
    write_reg(CFG_MAX_ITER, 32'hFFFF_0000);
    send_pixel(5, 5);
    send_pixel(1023, 0);
    wait_idle();

    // steps with the top data bit set must be masked; unmapped indexes ignored
    load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, 32'h8000_0000 | RST_STEP_REAL,
              32'h8000_0000 | RST_STEP_IMAG, 100);
    for (int k = CFG_MAX_ITER + 1; k <= LAST_INDEX; k++)
      write_reg(CFG_INDEX_BITS'(k), $urandom);
    send_pixel(100, 200);
    send_pixel(700, 300);
    send_pixel(340, 400);
    wait_idle();
    views_run = 5;

    // random views, each followed by a batch of random pixels
    while (items_sent < ITEM_TARGET) begin
      random_view();
      feed_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(60, 140)) send_pixel(pick_index(), pick_index());
      wait_idle();
      views_run++;
    end

    // anything arriving now would be an unexpected item
    repeat (DRAIN_CYCLES) @(posedge clk);

    bands_seen = 0;
    foreach (pix_sb.bands_hit[b]) if (pix_sb.bands_hit[b] != 0) bands_seen++;
    $display("%0d pixels over %0d views, %0d output items compared",
             items_sent, views_run, pix_sb.checked);
    $display("%0d of %0d palette bands reached; %0d mismatches",
             bands_seen, NUM_BANDS, pix_sb.errors);
    if (pix_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("cycle limit reached with %0d items outstanding", pix_sb.pending());
    $display("FAILURE");
    $finish;
  end

endmodule
